[design/rcx_pkg.sv]
package rcx_pkg;

   // Field widths
   localparam int CH_W     = 8;
   localparam int COEF_W   = 17;
   localparam int PROD_W   = 25;
   localparam int SX_W     = 24;
   localparam int SY_W     = 24;
   localparam int SZ_W     = 25;
   localparam int TOT_W    = 26;
   localparam int DVD_W    = 42;
   localparam int QUO_W    = 17;
   localparam int CHROMA_W = 16;
   localparam int LUM_W    = 15;
   localparam int LSCL_W   = 31;
   localparam int LNUM_W   = 23;
   localparam int LPROD_W  = 48;
   localparam int RECIP_SH = 32;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_W     = 16;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_NEUTRAL_X = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_NEUTRAL_Y = 1'd1;

   // Register reset values, Q0.16
   localparam logic [CSR_W-1:0] NEUTRAL_X_RESET = 16'd20316;
   localparam logic [CSR_W-1:0] NEUTRAL_Y_RESET = 16'd20709;

   // Monitor primaries in Q1.16, one row per output component
   localparam logic [COEF_W-1:0] COEF_X [3] = '{17'd32636, 17'd18979, 17'd12676};
   localparam logic [COEF_W-1:0] COEF_Y [3] = '{17'd17981, 17'd41640, 17'd5915};
   localparam logic [COEF_W-1:0] COEF_Z [3] = '{17'd1351, 17'd10197, 17'd65915};

   // Luminance: (Y*100 + 32640) / 65280, done as ((..) >> 8) / 255
   localparam logic [LSCL_W-1:0]  LUM_SCALE = 31'd100;
   localparam logic [LSCL_W-1:0]  LUM_HALF  = 31'd32640;
   // ceil(2^32 / 255); exact for every numerator below 2^23
   localparam logic [LPROD_W-1:0] LUM_RECIP = 48'd16843010;

   // Range limits
   localparam logic [QUO_W-1:0] Q16_ONE = 17'd65536;
   localparam logic [LUM_W-1:0] LUM_MAX = 15'd25600;

   typedef struct packed {
      logic [TOT_W-1:0] total;
      logic [LUM_W-1:0] lum;
      logic             sy_zero;
      logic             total_zero;
   } rcx_side_type;

   typedef struct packed {
      logic [DVD_W-1:0] num_x;
      logic [DVD_W-1:0] num_y;
      rcx_side_type     side;
   } rcx_div_in_type;

   typedef struct packed {
      logic [QUO_W-1:0] quo_x;
      logic [QUO_W-1:0] quo_y;
      rcx_side_type     side;
   } rcx_div_out_type;

   typedef struct packed {
      logic [TOT_W-1:0] rem;
      logic [QUO_W-1:0] low;
      logic [QUO_W-1:0] quo;
   } rcx_lane_type;

   // One restoring division step: bring down one dividend bit, subtract if it fits
   function automatic rcx_lane_type div_step(rcx_lane_type lane, logic [TOT_W-1:0] total,
                                             logic nbit);
      logic [TOT_W:0] trial;
      rcx_lane_type   res;
      trial = {lane.rem, nbit};
      res   = lane;
      if (trial >= {1'b0, total}) begin
         res.rem = TOT_W'(trial - {1'b0, total});
         res.quo = {lane.quo[QUO_W-2:0], 1'b1};
      end else begin
         res.rem = trial[TOT_W-1:0];
         res.quo = {lane.quo[QUO_W-2:0], 1'b0};
      end
      return res;
   endfunction

endpackage

[design/rgb_to_cie_xyy.sv]
// An accepted req_ beat passes 4 matrix stages, 17 divider stages of one quotient bit each
// and 1 output register before its rsp_ beat is valid.
// Throughput: one pixel per cycle; the whole pipeline holds only while a result beat
// waits with rsp_tready low.
// Reset: synchronous, active high; clears all valid bits and loads neutral_x = 20316
// and neutral_y = 20709. Payload registers are not reset.
module rgb_to_cie_xyy (
   input  logic                              clock,
   input  logic                              reset,
   // Pixel in
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [23:0]                       req_tdata,  // red, green, blue
   // Result out
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [47:0]                       rsp_tdata,  // chroma_x, chroma_y, luminance,
                                                         // out_of_range
   // Register writes
   input  logic                              csr_we,
   input  logic [rcx_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [rcx_pkg::CSR_W-1:0]         csr_wdata
);

   logic                         advance;
   logic                         mat_valid, div_valid;
   rcx_pkg::rcx_div_in_type      mat_data;
   rcx_pkg::rcx_div_out_type     div_data;

   logic [rcx_pkg::CSR_W-1:0]    neutral_x_ff, neutral_y_ff;

   logic                         rsp_valid_ff;
   logic [rcx_pkg::CHROMA_W-1:0] chroma_x_in, chroma_y_in, chroma_x_ff, chroma_y_ff;
   logic [rcx_pkg::LUM_W-1:0]    lum_ff;
   logic                         oor_in, oor_ff;
   logic                         use_nx;

   // Move every stage when the output slot is free or being taken
   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = advance;

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         neutral_x_ff <= rcx_pkg::NEUTRAL_X_RESET;
         neutral_y_ff <= rcx_pkg::NEUTRAL_Y_RESET;
      end else if (csr_we) begin
         case (csr_index)
            rcx_pkg::CSR_NEUTRAL_X: neutral_x_ff <= csr_wdata;
            rcx_pkg::CSR_NEUTRAL_Y: neutral_y_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   rcx_matrix u_matrix (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (req_tvalid),
      .red       (req_tdata[7:0]),
      .green     (req_tdata[15:8]),
      .blue      (req_tdata[23:16]),
      .out_valid (mat_valid),
      .out_data  (mat_data)
   );

   rcx_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (mat_valid),
      .in_data   (mat_data),
      .out_valid (div_valid),
      .out_data  (div_data)
   );

   // Pick neutral point, saturate, flag out-of-range
   always_comb begin
      use_nx = div_data.side.sy_zero || div_data.side.total_zero;
      if (use_nx) begin
         chroma_x_in = neutral_x_ff;
      end else if (div_data.quo_x[rcx_pkg::QUO_W-1]) begin
         chroma_x_in = '1;
      end else begin
         chroma_x_in = div_data.quo_x[rcx_pkg::CHROMA_W-1:0];
      end
      if (div_data.side.total_zero) begin
         chroma_y_in = neutral_y_ff;
      end else if (div_data.quo_y[rcx_pkg::QUO_W-1]) begin
         chroma_y_in = '1;
      end else begin
         chroma_y_in = div_data.quo_y[rcx_pkg::CHROMA_W-1:0];
      end
      oor_in = (!use_nx && (div_data.quo_x > rcx_pkg::Q16_ONE))
            || (!div_data.side.total_zero && (div_data.quo_y > rcx_pkg::Q16_ONE))
            || (div_data.side.lum > rcx_pkg::LUM_MAX);
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= div_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         chroma_x_ff <= chroma_x_in;
         chroma_y_ff <= chroma_y_in;
         lum_ff      <= div_data.side.lum;
         oor_ff      <= oor_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {oor_ff, lum_ff, chroma_y_ff, chroma_x_ff};

endmodule

[design/rcx_matrix.sv]
module rcx_matrix (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        advance,
   input  logic                        in_valid,
   input  logic [rcx_pkg::CH_W-1:0]    red,
   input  logic [rcx_pkg::CH_W-1:0]    green,
   input  logic [rcx_pkg::CH_W-1:0]    blue,
   output logic                        out_valid,
   output rcx_pkg::rcx_div_in_type     out_data
);

   logic [3:0] valid_ff;

   logic [rcx_pkg::CH_W-1:0]   ch [3];
   logic [rcx_pkg::PROD_W-1:0] px_in [3], py_in [3], pz_in [3];
   logic [rcx_pkg::PROD_W-1:0] px_ff [3], py_ff [3], pz_ff [3];

   logic [rcx_pkg::SX_W-1:0] sx_in, sx_ff, sx3_ff;
   logic [rcx_pkg::SY_W-1:0] sy_in, sy_ff, sy3_ff;
   logic [rcx_pkg::SZ_W-1:0] sz_in, sz_ff;

   logic [rcx_pkg::TOT_W-1:0]  total_in, total_ff, total4_ff;
   logic [rcx_pkg::LSCL_W-1:0] lscl;
   logic [rcx_pkg::LNUM_W-1:0] lnum_in, lnum_ff;

   logic [rcx_pkg::DVD_W-1:0]   num_x_in, num_y_in, num_x_ff, num_y_ff;
   logic [rcx_pkg::LPROD_W-1:0] lprod_in, lprod_ff;
   logic                        sy_zero_ff, total_zero_ff;

   // Advance valid bits together with the payload
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= {valid_ff[2:0], in_valid};
      end
   end

   // Stage 1: nine coefficient products
   always_comb begin
      ch[0] = red;
      ch[1] = green;
      ch[2] = blue;
      for (int i = 0; i < 3; i++) begin
         px_in[i] = rcx_pkg::PROD_W'(ch[i]) * rcx_pkg::PROD_W'(rcx_pkg::COEF_X[i]);
         py_in[i] = rcx_pkg::PROD_W'(ch[i]) * rcx_pkg::PROD_W'(rcx_pkg::COEF_Y[i]);
         pz_in[i] = rcx_pkg::PROD_W'(ch[i]) * rcx_pkg::PROD_W'(rcx_pkg::COEF_Z[i]);
      end
   end

   // Stage 2: X, Y and Z sums
   assign sx_in = rcx_pkg::SX_W'(px_ff[0]) + rcx_pkg::SX_W'(px_ff[1])
                + rcx_pkg::SX_W'(px_ff[2]);
   assign sy_in = rcx_pkg::SY_W'(py_ff[0]) + rcx_pkg::SY_W'(py_ff[1])
                + rcx_pkg::SY_W'(py_ff[2]);
   assign sz_in = rcx_pkg::SZ_W'(pz_ff[0]) + rcx_pkg::SZ_W'(pz_ff[1])
                + rcx_pkg::SZ_W'(pz_ff[2]);

   // Stage 3: total and scaled luminance numerator
   assign total_in = rcx_pkg::TOT_W'(sx_ff) + rcx_pkg::TOT_W'(sy_ff)
                   + rcx_pkg::TOT_W'(sz_ff);
   assign lscl     = rcx_pkg::LSCL_W'(sy_ff) * rcx_pkg::LUM_SCALE + rcx_pkg::LUM_HALF;
   assign lnum_in  = lscl[rcx_pkg::LSCL_W-1:8];

   // Stage 4: rounded dividends and reciprocal product for luminance
   assign num_x_in = rcx_pkg::DVD_W'({sx3_ff, 16'h0000})
                   + rcx_pkg::DVD_W'(total_ff[rcx_pkg::TOT_W-1:1]);
   assign num_y_in = rcx_pkg::DVD_W'({sy3_ff, 16'h0000})
                   + rcx_pkg::DVD_W'(total_ff[rcx_pkg::TOT_W-1:1]);
   assign lprod_in = rcx_pkg::LPROD_W'(lnum_ff) * rcx_pkg::LUM_RECIP;

   always_ff @(posedge clock) begin
      if (advance) begin
         px_ff         <= px_in;
         py_ff         <= py_in;
         pz_ff         <= pz_in;
         sx_ff         <= sx_in;
         sy_ff         <= sy_in;
         sz_ff         <= sz_in;
         total_ff      <= total_in;
         lnum_ff       <= lnum_in;
         sx3_ff        <= sx_ff;
         sy3_ff        <= sy_ff;
         num_x_ff      <= num_x_in;
         num_y_ff      <= num_y_in;
         lprod_ff      <= lprod_in;
         total4_ff     <= total_ff;
         sy_zero_ff    <= (sy3_ff == '0);
         total_zero_ff <= (total_ff == '0);
      end
   end

   assign out_valid                = valid_ff[3];
   assign out_data.num_x           = num_x_ff;
   assign out_data.num_y           = num_y_ff;
   assign out_data.side.total      = total4_ff;
   assign out_data.side.lum        =
      lprod_ff[rcx_pkg::RECIP_SH+rcx_pkg::LUM_W-1:rcx_pkg::RECIP_SH];
   assign out_data.side.sy_zero    = sy_zero_ff;
   assign out_data.side.total_zero = total_zero_ff;

endmodule

[design/rcx_divider.sv]
module rcx_divider (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     advance,
   input  logic                     in_valid,
   input  rcx_pkg::rcx_div_in_type  in_data,
   output logic                     out_valid,
   output rcx_pkg::rcx_div_out_type out_data
);

   localparam int NSTG = rcx_pkg::QUO_W;

   logic [NSTG-1:0]       valid_ff;
   rcx_pkg::rcx_lane_type x_ff    [NSTG];
   rcx_pkg::rcx_lane_type y_ff    [NSTG];
   rcx_pkg::rcx_side_type side_ff [NSTG];

   // One quotient bit per stage, both lanes share the divisor
   for (genvar k = 0; k < NSTG; k++) begin : g_stage
      rcx_pkg::rcx_lane_type x_prev, y_prev, x_in, y_in;
      rcx_pkg::rcx_side_type side_prev;
      logic                  valid_prev;

      if (k == 0) begin : g_first
         // Top dividend bits seed the remainder; the quotient fits in QUO_W bits
         assign x_prev.rem = rcx_pkg::TOT_W'(in_data.num_x[rcx_pkg::DVD_W-1:rcx_pkg::QUO_W]);
         assign x_prev.low = in_data.num_x[rcx_pkg::QUO_W-1:0];
         assign x_prev.quo = '0;
         assign y_prev.rem = rcx_pkg::TOT_W'(in_data.num_y[rcx_pkg::DVD_W-1:rcx_pkg::QUO_W]);
         assign y_prev.low = in_data.num_y[rcx_pkg::QUO_W-1:0];
         assign y_prev.quo = '0;
         assign side_prev  = in_data.side;
         assign valid_prev = in_valid;
      end else begin : g_next
         assign x_prev     = x_ff[k-1];
         assign y_prev     = y_ff[k-1];
         assign side_prev  = side_ff[k-1];
         assign valid_prev = valid_ff[k-1];
      end

      assign x_in = rcx_pkg::div_step(x_prev, side_prev.total, x_prev.low[NSTG-1-k]);
      assign y_in = rcx_pkg::div_step(y_prev, side_prev.total, y_prev.low[NSTG-1-k]);

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (advance) begin
            valid_ff[k] <= valid_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            x_ff[k]    <= x_in;
            y_ff[k]    <= y_in;
            side_ff[k] <= side_prev;
         end
      end
   end

   assign out_valid      = valid_ff[NSTG-1];
   assign out_data.quo_x = x_ff[NSTG-1].quo;
   assign out_data.quo_y = y_ff[NSTG-1].quo;
   assign out_data.side  = side_ff[NSTG-1];

endmodule
